[rtl/core/vfcm_pkg.sv]
// Shared types, constants and lookup functions for the voxel face mesher.
package vfcm_pkg;

    localparam int GridXz     = 18;
    localparam int GridHeight = 128;
    localparam int StoreDepth = GridXz * GridHeight * GridXz;
    localparam int AddrW      = $clog2(StoreDepth);
    localparam int XzW        = 5;
    localparam int YW         = 7;
    localparam int CntW       = 20;
    localparam logic [CntW-1:0] CountMax = {CntW{1'b1}};

    typedef enum logic [1:0] {
        K_WRITE = 2'd0,
        K_MESH  = 2'd1,
        K_CLEAR = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [XzW-1:0]   x;
        logic [YW-1:0]    y;
        logic [XzW-1:0]   z;
        logic [7:0]       btype;
    } t_cmd;

    typedef struct packed {
        logic [XzW-1:0] x;
        logic [7:0]     y;
        logic [XzW-1:0] z;
        logic [2:0]     face;
        logic [1:0]     corner;
        logic [1:0]     u;
        logic [1:0]     v;
        logic [CntW-1:0] idx;
        logic           last;
    } t_vert;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CENTER,
        S_NBR,
        S_EMIT,
        S_CLEAR
    } t_state;

    localparam int QDepth = 4;

    // Linear address of an in-grid voxel.
    function automatic logic [AddrW-1:0] cell_addr(input logic [XzW-1:0] x,
                                                   input logic [YW:0] y,
                                                   input logic [XzW-1:0] z);
        logic [AddrW+1:0] a;
        a = ((AddrW+2)'(x) * (AddrW+2)'(GridHeight) + (AddrW+2)'(y))
            * (AddrW+2)'(GridXz) + (AddrW+2)'(z);
        return a[AddrW-1:0];
    endfunction

    // Cube corner (bit0 x, bit1 y, bit2 z) for face f, quad corner c.
    function automatic logic [2:0] face_corner(input logic [2:0] f, input logic [1:0] c);
        logic [2:0] p;
        logic [2:0] xyz;
        case ({f, c})
            {3'd0, 2'd0}: p = 3'd4; {3'd0, 2'd1}: p = 3'd7;
            {3'd0, 2'd2}: p = 3'd6; {3'd0, 2'd3}: p = 3'd5;
            {3'd1, 2'd0}: p = 3'd3; {3'd1, 2'd1}: p = 3'd0;
            {3'd1, 2'd2}: p = 3'd1; {3'd1, 2'd3}: p = 3'd2;
            {3'd2, 2'd0}: p = 3'd7; {3'd2, 2'd1}: p = 3'd3;
            {3'd2, 2'd2}: p = 3'd2; {3'd2, 2'd3}: p = 3'd6;
            {3'd3, 2'd0}: p = 3'd0; {3'd3, 2'd1}: p = 3'd4;
            {3'd3, 2'd2}: p = 3'd5; {3'd3, 2'd3}: p = 3'd1;
            {3'd4, 2'd0}: p = 3'd2; {3'd4, 2'd1}: p = 3'd1;
            {3'd4, 2'd2}: p = 3'd5; {3'd4, 2'd3}: p = 3'd6;
            {3'd5, 2'd0}: p = 3'd0; {3'd5, 2'd1}: p = 3'd3;
            {3'd5, 2'd2}: p = 3'd7; {3'd5, 2'd3}: p = 3'd4;
            default:      p = 3'd0;
        endcase
        // Corner numbering: 0..3 at z=0, 4..7 at z=1; x set for 2,3,6,7; y for 1,2,5,6.
        xyz[0] = (p[1:0] == 2'd2) || (p[1:0] == 2'd3);
        xyz[1] = (p[1:0] == 2'd1) || (p[1:0] == 2'd2);
        xyz[2] = p[2];
        return xyz;
    endfunction

endpackage

[rtl/core/vfcm_front.sv]
// Front end: accepts input words and queues them as commands for the back end.
module vfcm_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  vfcm_pkg::t_cmd      i_cmd,
    input  logic                i_take,
    output logic                o_avail,
    output vfcm_pkg::t_cmd      o_cmd
);
    localparam int PW = $clog2(vfcm_pkg::QDepth);

    vfcm_pkg::t_cmd r_mem [vfcm_pkg::QDepth];
    logic [PW-1:0]  r_wp, r_rp;
    logic [PW:0]    r_cnt;
    logic           w_put, w_get;

    assign o_full  = (r_cnt == (PW+1)'(vfcm_pkg::QDepth));
    assign o_avail = (r_cnt != '0);
    assign w_put   = i_push && !o_full;
    assign w_get   = i_take && o_avail;
    assign o_cmd   = r_mem[r_rp];

    // Unused kinds are dropped here so the back end never sees them.
    always_ff @(posedge i_clk) begin
        if (w_put && i_cmd.kind != vfcm_pkg::K_NONE) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_put && i_cmd.kind != vfcm_pkg::K_NONE) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_get) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(w_put && i_cmd.kind != vfcm_pkg::K_NONE)
                           - (PW+1)'(w_get);
        end
    end
endmodule

[rtl/core/vfcm_back.sv]
// Back end: voxel memory, neighbour tests and vertex generation.
module vfcm_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_avail,
    input  vfcm_pkg::t_cmd      i_cmd,
    output logic                o_take,
    output logic                o_vld,
    output vfcm_pkg::t_vert     o_vert,
    input  logic                i_pop
);
    localparam int AW = vfcm_pkg::AddrW;
    localparam int CW = vfcm_pkg::CntW;
    localparam int XW = vfcm_pkg::XzW;

    logic [7:0]          r_mem [vfcm_pkg::StoreDepth];
    logic [7:0]          r_rd;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [7:0]          w_wdata;
    logic [AW-1:0]       w_raddr;

    vfcm_pkg::t_state    r_state, n_state;
    vfcm_pkg::t_cmd      r_cmd, n_cmd;
    logic [7:0]          r_type, n_type;
    logic [2:0]          r_step, n_step;
    logic [2:0]          r_face, n_face;
    logic [1:0]          r_corner, n_corner;
    logic [5:0]          r_exp, n_exp;
    logic                r_nin;
    logic [AW-1:0]       r_clr, n_clr;
    logic [CW-1:0]       r_count, n_count;
    logic                r_ovld, n_ovld;
    vfcm_pkg::t_vert     r_out, n_out;

    logic [5:0]  w_nx;
    logic [7:0]  w_ny;
    logic [5:0]  w_nz;
    logic        w_in;
    logic        w_open;
    logic        w_emit;
    logic [5:0]  w_exp;
    logic [2:0]  w_first;
    logic [2:0]  w_xyz;
    logic [1:0]  w_col, w_row;
    logic [5:0]  w_rest;
    logic        w_more;
    logic [2:0]  w_nf;

    // Memory: one write port for the clearing pass and write words, one registered read.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    // Read address: the centre voxel, or the neighbour of face r_step while probing.
    always_comb begin
        w_nx = {1'b0, r_cmd.x};
        w_ny = {1'b0, r_cmd.y};
        w_nz = {1'b0, r_cmd.z};
        if (r_state == vfcm_pkg::S_NBR) begin
            case (r_step)
                3'd0: w_nz = w_nz + 6'd1;
                3'd1: w_nz = w_nz - 6'd1;
                3'd2: w_nx = w_nx + 6'd1;
                3'd3: w_nx = w_nx - 6'd1;
                3'd4: w_ny = w_ny + 8'd1;
                3'd5: w_ny = w_ny - 8'd1;
                default: ;
            endcase
        end
        w_in = (w_nx < 6'(vfcm_pkg::GridXz)) && (w_ny < 8'(vfcm_pkg::GridHeight))
            && (w_nz < 6'(vfcm_pkg::GridXz));
        w_raddr = w_in ? vfcm_pkg::cell_addr(w_nx[4:0], w_ny, w_nz[4:0]) : '0;
    end

    // A returned read that is outside the grid, empty or a custom model counts as open.
    assign w_open = !r_nin || r_rd == 8'd0 || r_rd == 8'd4;
    assign w_emit = (r_state == vfcm_pkg::S_EMIT) && (!r_ovld || i_pop);

    always_comb begin
        // Exposure bits shift in from the top, face 0 first.
        w_exp   = {w_open, r_exp[5:1]};
        w_first = 3'd0;
        for (int i = 5; i >= 0; i--) begin
            if (w_exp[i]) begin
                w_first = 3'(i);
            end
        end
        w_xyz = vfcm_pkg::face_corner(r_face, r_corner);
        if (r_type == 8'd3) begin
            w_col = 2'd1; w_row = 2'd0;
        end else if (r_type == 8'd2) begin
            w_col = 2'd0; w_row = 2'd2;
        end else begin
            w_col = 2'd0;
            w_row = (r_face == 3'd4) ? 2'd0 : (r_face == 3'd5) ? 2'd2 : 2'd1;
        end
        // Exposed faces after the current one.
        w_rest = r_exp & ~((6'd2 << r_face) - 6'd1);
        w_more = (w_rest != '0);
        w_nf   = 3'd0;
        for (int i = 5; i >= 0; i--) begin
            if (w_rest[i]) begin
                w_nf = 3'(i);
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            vfcm_pkg::S_CLEAR: begin
                if (r_clr == AW'(vfcm_pkg::StoreDepth - 1)) n_state = vfcm_pkg::S_IDLE;
            end
            vfcm_pkg::S_IDLE: begin
                if (i_avail && i_cmd.kind == vfcm_pkg::K_MESH) n_state = vfcm_pkg::S_CENTER;
            end
            vfcm_pkg::S_CENTER: n_state = vfcm_pkg::S_NBR;
            vfcm_pkg::S_NBR: begin
                if (r_step == 3'd0) begin
                    // An empty, custom or outside centre voxel gives no faces.
                    if (w_open) n_state = vfcm_pkg::S_IDLE;
                end else if (r_step == 3'd6) begin
                    n_state = (w_exp != '0) ? vfcm_pkg::S_EMIT : vfcm_pkg::S_IDLE;
                end
            end
            vfcm_pkg::S_EMIT: begin
                if (w_emit && r_corner == 2'd3 && !w_more) n_state = vfcm_pkg::S_IDLE;
            end
            default: n_state = vfcm_pkg::S_IDLE;
        endcase
    end

    // Outputs and datapath.
    always_comb begin
        n_cmd    = r_cmd;
        n_type   = r_type;
        n_step   = r_step;
        n_face   = r_face;
        n_corner = r_corner;
        n_exp    = r_exp;
        n_clr    = r_clr;
        n_count  = r_count;
        n_ovld   = r_ovld && !i_pop;
        n_out    = r_out;
        w_we     = 1'b0;
        w_waddr  = r_clr;
        w_wdata  = 8'd0;
        o_take   = 1'b0;
        case (r_state)
            vfcm_pkg::S_CLEAR: begin
                w_we  = 1'b1;
                n_clr = r_clr + 1'b1;
            end
            vfcm_pkg::S_IDLE: begin
                if (i_avail) begin
                    o_take = 1'b1;
                    n_cmd  = i_cmd;
                    n_step = 3'd0;
                    case (i_cmd.kind)
                        vfcm_pkg::K_WRITE: begin
                            w_we    = ({1'b0, i_cmd.x} < 6'(vfcm_pkg::GridXz))
                                   && ({1'b0, i_cmd.z} < 6'(vfcm_pkg::GridXz));
                            w_waddr = vfcm_pkg::cell_addr(i_cmd.x, {1'b0, i_cmd.y}, i_cmd.z);
                            w_wdata = i_cmd.btype;
                        end
                        vfcm_pkg::K_CLEAR: n_count = '0;
                        default: ;
                    endcase
                end
            end
            vfcm_pkg::S_CENTER: n_step = 3'd0;
            vfcm_pkg::S_NBR: begin
                // Step 0 returns the centre, steps 1 to 6 return faces 0 to 5.
                n_step = r_step + 3'd1;
                if (r_step == 3'd0) begin
                    n_type = r_rd;
                end else begin
                    n_exp = w_exp;
                end
                if (r_step == 3'd6) begin
                    n_face   = w_first;
                    n_corner = 2'd0;
                end
            end
            vfcm_pkg::S_EMIT: begin
                if (w_emit) begin
                    n_ovld       = 1'b1;
                    n_out.x      = r_cmd.x + XW'(w_xyz[0]);
                    n_out.y      = {1'b0, r_cmd.y} + 8'(w_xyz[1]);
                    n_out.z      = r_cmd.z + XW'(w_xyz[2]);
                    n_out.face   = r_face;
                    n_out.corner = r_corner;
                    n_out.u      = w_col + 2'((r_corner == 2'd1) || (r_corner == 2'd2));
                    n_out.v      = w_row + 2'd1 - 2'(r_corner[1]);
                    n_out.idx    = r_count;
                    n_out.last   = (r_corner == 2'd3) && !w_more;
                    if (r_count != vfcm_pkg::CountMax) n_count = r_count + 1'b1;
                    n_corner = r_corner + 2'd1;
                    if (r_corner == 2'd3) n_face = w_nf;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_type   <= n_type;
        r_step   <= n_step;
        r_face   <= n_face;
        r_corner <= n_corner;
        r_exp    <= n_exp;
        r_nin    <= w_in;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vfcm_pkg::S_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_count <= n_count;
            r_ovld  <= n_ovld;
        end
    end

    assign o_vld  = r_ovld;
    assign o_vert = r_out;
endmodule

[rtl/core/voxel_face_cull_mesher_top.sv]
// Top level of the culled voxel face mesher: front end with its input queue, and back end.
// A mesh word holds the back end through the take, the centre read and six neighbour reads on
// the one memory port, after which its first vertex word is registered on the outputs; it then
// emits one vertex per cycle unless a vertex waits for pop. An empty voxel leaves after the
// centre read, write and clear words after the take, and unused words never reach it. Reset is
// synchronous, active low; a clearing pass then zeroes all 41472 memory words, and meanwhile
// pushed words wait in the 4-entry input queue, which raises full once they fill it.
module voxel_face_cull_mesher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_kind,
    input  logic [4:0]  i_voxel_x,
    input  logic [6:0]  i_voxel_y,
    input  logic [4:0]  i_voxel_z,
    input  logic [7:0]  i_block_type,
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  o_vert_x,
    output logic [7:0]  o_vert_y,
    output logic [4:0]  o_vert_z,
    output logic [2:0]  o_face_id,
    output logic [1:0]  o_corner,
    output logic [1:0]  o_tex_u_halves,
    output logic [1:0]  o_tex_v_thirds,
    output logic [19:0] o_vertex_index,
    output logic        o_last_of_run
);
    vfcm_pkg::t_cmd  w_in_cmd, w_q_cmd;
    vfcm_pkg::t_vert w_vert;
    logic            w_avail, w_take, w_vld;

    // The input word is packed into a command for the queue.
    assign w_in_cmd.kind  = vfcm_pkg::t_kind'(i_kind);
    assign w_in_cmd.x     = i_voxel_x;
    assign w_in_cmd.y     = i_voxel_y;
    assign w_in_cmd.z     = i_voxel_z;
    assign w_in_cmd.btype = i_block_type;

    vfcm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_cmd   (w_in_cmd),
        .i_take  (w_take),
        .o_avail (w_avail),
        .o_cmd   (w_q_cmd)
    );

    // The back end holds one finished vertex word in its output register.
    vfcm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (w_avail),
        .i_cmd   (w_q_cmd),
        .o_take  (w_take),
        .o_vld   (w_vld),
        .o_vert  (w_vert),
        .i_pop   (pop)
    );

    assign empty          = !w_vld;
    assign o_vert_x       = w_vert.x;
    assign o_vert_y       = w_vert.y;
    assign o_vert_z       = w_vert.z;
    assign o_face_id      = w_vert.face;
    assign o_corner       = w_vert.corner;
    assign o_tex_u_halves = w_vert.u;
    assign o_tex_v_thirds = w_vert.v;
    assign o_vertex_index = w_vert.idx;
    assign o_last_of_run  = w_vert.last;
endmodule

[rtl/core/vfcm_checker.sv]
// Port-level checker for the voxel face mesher, bound to the top level.
module vfcm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  o_face_id,
    input logic [1:0]  o_corner,
    input logic [1:0]  o_tex_u_halves,
    input logic [19:0] o_vertex_index,
    input logic        o_last_of_run
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_vertex_index))
        else $error("waiting word changed");
    a_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_face_id <= 3'd5 && o_tex_u_halves <= 2'd2)
        else $error("face or u out of range");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_last_of_run |-> o_corner == 2'd3)
        else $error("run ended mid quad");
    a_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && pop && o_corner != 2'd3 |=> !empty && o_corner == $past(o_corner) + 2'd1)
        else $error("quad corner missing");
endmodule

bind voxel_face_cull_mesher_top vfcm_checker u_vfcm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .empty          (empty),
    .pop            (pop),
    .o_face_id      (o_face_id),
    .o_corner       (o_corner),
    .o_tex_u_halves (o_tex_u_halves),
    .o_vertex_index (o_vertex_index),
    .o_last_of_run  (o_last_of_run)
);
